/* sv/uaob_pkg.sv */
// Shared types and constants for the unmultiply-and-blend pixel pipeline.
package uaob_pkg;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned NUM_CH     = 3;
  localparam int unsigned NUM_W      = 16;   // width of 255 * channel
  localparam int unsigned RECIP_SHIFT = 24;  // fixed point of the reciprocal table
  localparam int unsigned RECIP_W    = RECIP_SHIFT + 1;
  localparam int unsigned TABLE_N    = 256;

  localparam logic [CH_W-1:0] ALPHA_OPAQUE      = 8'hff;
  localparam logic [CH_W-1:0] ALPHA_TRANSPARENT = 8'h00;
  localparam logic [CH_W-1:0] FULL_SCALE        = 8'd255;

  // One input pixel pair as it travels down the pipeline
  typedef struct packed {
    logic [NUM_CH-1:0][CH_W-1:0] fch;
    logic [CH_W-1:0]             alpha;
    logic [NUM_CH-1:0][CH_W-1:0] bch;
    logic                        last;
  } pix_t;

  // Unmultiplied front channels with the original pixel alongside
  typedef struct packed {
    logic [NUM_CH-1:0][CH_W-1:0] un;
    pix_t                        pix;
  } unm_t;

endpackage

/* sv/uaob_unmul.sv */
// Four-stage unmultiply: floor(255*c/alpha) by reciprocal multiply and one-step correction.
module uaob_unmul (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  uaob_pkg::pix_t in_pix,
  output logic          out_valid,
  input  logic          out_ready,
  output uaob_pkg::unm_t out_unm
);
  import uaob_pkg::*;

  localparam int unsigned NStg   = 4;
  localparam int unsigned ProdW  = NUM_W + RECIP_W;

  // Reciprocal table floor(2^24 / a), worked out at elaboration
  logic [RECIP_W-1:0] recip_tab [TABLE_N];
  for (genvar g = 0; g < TABLE_N; g++) begin : g_recip
    localparam logic [RECIP_W-1:0] RecipVal =
      RECIP_W'((64'd1 << RECIP_SHIFT) / ((g == 0) ? 1 : g));
    assign recip_tab[g] = RecipVal;
  end

  logic [NStg-1:0] v_r;
  logic [NStg-1:0] en;

  // Stage registers
  logic [NUM_CH-1:0][NUM_W-1:0]  n1_r, n2_r, n3_r;
  logic [RECIP_W-1:0]            rc1_r;
  logic [NUM_CH-1:0][NUM_W-1:0]  q2_r, q3_r;
  logic [NUM_CH-1:0][NUM_W-1:0]  t3_r;
  logic [NUM_CH-1:0][CH_W-1:0]   un4_r;
  pix_t                          pix1_r, pix2_r, pix3_r, pix4_r;

  // Combinational values between stages
  logic [NUM_CH-1:0][NUM_W-1:0]  n1_nxt;
  logic [NUM_CH-1:0][NUM_W-1:0]  q2_nxt;
  logic [NUM_CH-1:0][NUM_W-1:0]  t3_nxt;
  logic [NUM_CH-1:0][CH_W-1:0]   un4_nxt;
  logic [NUM_CH-1:0][ProdW-1:0]  prod2;
  logic [NUM_CH-1:0][NUM_W-1:0]  rem4;
  logic [NUM_CH-1:0][NUM_W-1:0]  qinc4;

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    en[NStg-1] = !v_r[NStg-1] || out_ready;
    for (int i = NStg - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NStg; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // Per-channel arithmetic of each stage
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      n1_nxt[c]  = {in_pix.fch[c], 8'h00} - NUM_W'(in_pix.fch[c]);
      prod2[c]   = ProdW'(n1_r[c]) * ProdW'(rc1_r);
      q2_nxt[c]  = prod2[c][RECIP_SHIFT +: NUM_W];
      t3_nxt[c]  = NUM_W'(q2_r[c] * NUM_W'(pix2_r.alpha));
      rem4[c]    = n3_r[c] - t3_r[c];
      qinc4[c]   = q3_r[c] + NUM_W'(1);
      un4_nxt[c] = (rem4[c] >= NUM_W'(pix3_r.alpha)) ? qinc4[c][CH_W-1:0]
                                                      : q3_r[c][CH_W-1:0];
    end
  end

  // Hold payload while stalled; no reset needed
  always_ff @(posedge clk) begin
    if (en[0]) begin
      n1_r   <= n1_nxt;
      rc1_r  <= recip_tab[in_pix.alpha];
      pix1_r <= in_pix;
    end
    if (en[1]) begin
      q2_r   <= q2_nxt;
      n2_r   <= n1_r;
      pix2_r <= pix1_r;
    end
    if (en[2]) begin
      t3_r   <= t3_nxt;
      q3_r   <= q2_r;
      n3_r   <= n2_r;
      pix3_r <= pix2_r;
    end
    if (en[3]) begin
      un4_r  <= un4_nxt;
      pix4_r <= pix3_r;
    end
  end

  assign out_valid   = v_r[NStg-1];
  assign out_unm.un  = un4_r;
  assign out_unm.pix = pix4_r;

`ifndef SYNTHESIS
  // Quotient estimate never overshoots, so the product stays at or under the numerator
  a_est_low : assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] && (pix3_r.alpha != ALPHA_TRANSPARENT) |->
      (t3_r[0] <= n3_r[0]) && (t3_r[1] <= n3_r[1]) && (t3_r[2] <= n3_r[2]))
    else $error("unmultiply estimate above true quotient");
`endif

endmodule

/* sv/uaob_blend.sv */
// Two-stage blend: weighted sum, then divide by 255 and pick the pass-through cases.
module uaob_blend (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  uaob_pkg::unm_t in_unm,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [uaob_pkg::NUM_CH-1:0][uaob_pkg::CH_W-1:0] out_ch,
  output logic           out_last
);
  import uaob_pkg::*;

  localparam int unsigned SumW = NUM_W + 1;

  logic v5_r, v6_r;
  logic en5, en6;

  logic [NUM_CH-1:0][NUM_W-1:0] m5_r;
  logic [NUM_CH-1:0][NUM_W-1:0] m5_nxt;
  pix_t                         pix5_r;
  logic [NUM_CH-1:0][CH_W-1:0]  ch6_r;
  logic [NUM_CH-1:0][CH_W-1:0]  ch6_nxt;
  logic                         last6_r;
  logic [NUM_CH-1:0][SumW-1:0]  y6;
  logic [NUM_CH-1:0][SumW-1:0]  s6;
  logic [CH_W-1:0]              inv_a;

  // Advance when empty or the next side takes
  assign en6      = !v6_r || out_ready;
  assign en5      = !v5_r || en6;
  assign in_ready = en5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en5) v5_r <= in_valid;
      if (en6) v6_r <= v5_r;
    end
  end

  assign inv_a = FULL_SCALE - in_unm.pix.alpha;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      // Weighted sum, at most 255*255; widen the operands so no product bits drop
      m5_nxt[c] = NUM_W'(in_unm.un[c]) * NUM_W'(in_unm.pix.alpha)
                + NUM_W'(in_unm.pix.bch[c]) * NUM_W'(inv_a);
      // Divide by 255: y = m + 1, (y + y/256) / 256
      y6[c] = SumW'(m5_r[c]) + SumW'(1);
      s6[c] = y6[c] + (y6[c] >> 8);
      unique case (pix5_r.alpha)
        ALPHA_TRANSPARENT: ch6_nxt[c] = pix5_r.bch[c];
        ALPHA_OPAQUE:      ch6_nxt[c] = pix5_r.fch[c];
        default:           ch6_nxt[c] = s6[c][8 +: CH_W];
      endcase
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    if (en5) begin
      m5_r   <= m5_nxt;
      pix5_r <= in_unm.pix;
    end
    if (en6) begin
      ch6_r   <= ch6_nxt;
      last6_r <= pix5_r.last;
    end
  end

  assign out_valid = v6_r;
  assign out_ch    = ch6_r;
  assign out_last  = last6_r;

`ifndef SYNTHESIS
  // Opaque front pixel passes straight through
  a_opaque : assert property (@(posedge clk) disable iff (!rst_n)
    en6 && v5_r && (pix5_r.alpha == ALPHA_OPAQUE) |=> (ch6_r == $past(pix5_r.fch)))
    else $error("opaque pixel not passed through");

  // Transparent front pixel gives the back pixel
  a_transp : assert property (@(posedge clk) disable iff (!rst_n)
    en6 && v5_r && (pix5_r.alpha == ALPHA_TRANSPARENT) |=> (ch6_r == $past(pix5_r.bch)))
    else $error("transparent pixel not giving back pixel");
`endif

endmodule

/* sv/unmultiply_alpha_over_blend_rgb.sv */
// Top level: premultiplied front pixel unmultiplied and blended over a back pixel.
//
//  channel | direction | tdata (low bit first)                        | tuser | tlast
//  in_     | slave     | front ch0,ch1,ch2, alpha, back ch0,ch1,ch2   | -     | last_in
//  out_    | master    | out ch0, ch1, ch2                            | -     | last_out
//
// One pixel per clock sustained while the output is not stalled; each word passes
// through the reciprocal-multiply unmultiply, then the blend and divide by 255.
// Every stage holds a valid bit and advances when it is empty or the next one
// advances, so bubbles close up while the output is stalled and nothing is lost.
// rst_n clears the valid bits only; data registers carry no reset.
module unmultiply_alpha_over_blend_rgb (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // front_ch0, front_ch1, front_ch2, front_alpha,
                                  // back_ch0, back_ch1, back_ch2
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_ch0, out_ch1, out_ch2
  output logic        out_tlast
);
  import uaob_pkg::*;

  pix_t in_pix;
  unm_t mid_unm;
  logic mid_valid, mid_ready;
  logic [NUM_CH-1:0][CH_W-1:0] res_ch;

  // Unpack the input word
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      in_pix.fch[c] = in_tdata[c*CH_W +: CH_W];
      in_pix.bch[c] = in_tdata[(NUM_CH + 1 + c)*CH_W +: CH_W];
    end
    in_pix.alpha = in_tdata[NUM_CH*CH_W +: CH_W];
    in_pix.last  = in_tlast;
  end

  uaob_unmul u_unmul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_pix    (in_pix),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_unm   (mid_unm)
  );

  uaob_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_unm    (mid_unm),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_ch    (res_ch),
    .out_last  (out_tlast)
  );

  assign out_tdata = res_ch;

`ifndef SYNTHESIS
  // Input back-pressure only appears behind a stalled, full output
  a_no_idle_stall : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled while output free");
`endif

endmodule
